// ===== design/log_record_header_checker_unit_macros.svh =====
// Assertion macros used by the log record header checker top level.
`ifndef LOG_RECORD_HEADER_CHECKER_UNIT_MACROS_SVH
`define LOG_RECORD_HEADER_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LRHC_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define LRHC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lrhc_pkg.sv =====
// Types, constants and the CRC-32 byte update for the log record header checker.
package lrhc_pkg;

    // Offset width default and fixed field widths
    localparam int OFFSET_BITS_DEF = 32;
    localparam int COUNT_W         = 28;
    localparam int OUT_DATA_W      = 472;
    localparam int OUT_PAD_W       = 4;

    // Header layout: end byte (exclusive) of each field
    localparam logic [5:0] CRC_END   = 6'd4;
    localparam logic [5:0] TS_END    = 6'd12;
    localparam logic [5:0] SEQ_END   = 6'd20;
    localparam logic [5:0] OP_END    = 6'd21;
    localparam logic [5:0] KEY_END   = 6'd23;
    localparam logic [5:0] VAL_END   = 6'd27;
    localparam logic [5:0] CIPH_END  = 6'd31;
    localparam logic [5:0] NLO_END   = 6'd39;
    localparam logic [5:0] NHI_END   = 6'd43;
    localparam logic [5:0] TLO_END   = 6'd51;
    localparam int         HDR_BYTES = 4 + 8 + 8 + 1 + 2 + 4 + 4 + 12 + 16;

    localparam logic [COUNT_W-1:0] HDR_BYTES_CNT = COUNT_W'(HDR_BYTES);
    localparam logic [COUNT_W-1:0] CRC_DONE_CNT  = COUNT_W'(CRC_END);
    localparam logic [31:0]        MAX_CIPHER    = 32'(128 * 1024 * 1024);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // Register address decode (word index)
    localparam logic REG_REGION_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_END_OF_LOG = 3'd1,
        ST_HDR_TRUNC  = 3'd2,
        ST_CIPHER_BIG = 3'd3,
        ST_BODY_TRUNC = 3'd4,
        ST_CRC_BAD    = 3'd5
    } rec_status_t;

    // Captured header fields
    typedef struct packed {
        logic [31:0] stored_crc;
        logic [63:0] timestamp;
        logic [63:0] sequence_number;
        logic [7:0]  operation;
        logic [15:0] key_length;
        logic [31:0] value_length;
        logic [31:0] cipher_length;
        logic [63:0] nonce_low;
        logic [31:0] nonce_high;
        logic [63:0] tag_low;
        logic [63:0] tag_high;
    } hdr_fields_t;

    // Capture control from the parser to the field capture
    typedef struct packed {
        logic       clear;
        logic       load;
        logic [5:0] index;
    } cap_ctrl_t;

    // Per-word outcome from the parser
    typedef struct packed {
        logic               emit;
        rec_status_t        status;
        logic [COUNT_W-1:0] total;
    } result_t;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/lrhc_field_capture.sv =====
// Header field capture: shifts each header byte into its little-endian field.
module lrhc_field_capture (
    input  logic                clk,
    input  logic                step,
    input  logic [7:0]          data_byte,
    input  lrhc_pkg::cap_ctrl_t cap,
    output lrhc_pkg::hdr_fields_t fields_next
);

    lrhc_pkg::hdr_fields_t fields_reg;
    lrhc_pkg::hdr_fields_t base;

    // Clear on a first byte, then shift the byte in from the top of its field
    always_comb
    begin
        base        = cap.clear ? '0 : fields_reg;
        fields_next = base;
        if (cap.load)
        begin
            priority if (cap.index < lrhc_pkg::CRC_END)
                fields_next.stored_crc = {data_byte, base.stored_crc[31:8]};
            else if (cap.index < lrhc_pkg::TS_END)
                fields_next.timestamp = {data_byte, base.timestamp[63:8]};
            else if (cap.index < lrhc_pkg::SEQ_END)
                fields_next.sequence_number = {data_byte, base.sequence_number[63:8]};
            else if (cap.index < lrhc_pkg::OP_END)
                fields_next.operation = data_byte;
            else if (cap.index < lrhc_pkg::KEY_END)
                fields_next.key_length = {data_byte, base.key_length[15:8]};
            else if (cap.index < lrhc_pkg::VAL_END)
                fields_next.value_length = {data_byte, base.value_length[31:8]};
            else if (cap.index < lrhc_pkg::CIPH_END)
                fields_next.cipher_length = {data_byte, base.cipher_length[31:8]};
            else if (cap.index < lrhc_pkg::NLO_END)
                fields_next.nonce_low = {data_byte, base.nonce_low[63:8]};
            else if (cap.index < lrhc_pkg::NHI_END)
                fields_next.nonce_high = {data_byte, base.nonce_high[31:8]};
            else if (cap.index < lrhc_pkg::TLO_END)
                fields_next.tag_low = {data_byte, base.tag_low[63:8]};
            else
                fields_next.tag_high = {data_byte, base.tag_high[63:8]};
        end
    end

    // Field storage
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            fields_reg <= fields_next;
        end
    end

endmodule

// ===== design/lrhc_parser.sv =====
// Record parser: byte count, running CRC, limit checks and result decision.
module lrhc_parser #(
    parameter int OFFSET_BITS = lrhc_pkg::OFFSET_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            data_byte,
    input  logic                  record_first,
    input  logic [31:0]           record_offset,
    input  logic [31:0]           region_limit,
    input  lrhc_pkg::hdr_fields_t fields_next,
    output lrhc_pkg::cap_ctrl_t   cap,
    output lrhc_pkg::result_t     res
);

    localparam int OFS_W = (OFFSET_BITS < 32) ? OFFSET_BITS : 32;
    localparam int CW    = lrhc_pkg::COUNT_W;
    localparam int SUM_W = ((OFS_W > CW) ? OFS_W : CW) + 1;

    logic             active_reg, active_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [31:0]      crc_reg, crc_next;
    logic [OFS_W-1:0] offset_reg, offset_next;

    logic          act_cur, proc;
    logic [CW-1:0] cnt_cur, cnt_inc, rec_total;
    logic [31:0]   crc_cur;
    logic [SUM_W-1:0] lim_ext, hdr_end, body_end;
    logic          hdr_trunc, eol, at_hdr_end, too_big, body_trunc, done;

    // Current view of the state, restarted on a first byte
    always_comb
    begin
        act_cur     = record_first | active_reg;
        cnt_cur     = record_first ? '0 : count_reg;
        crc_cur     = record_first ? lrhc_pkg::CRC_INIT : crc_reg;
        offset_next = record_first ? record_offset[OFS_W-1:0] : offset_reg;
    end

    // Limit arithmetic, no wrap
    always_comb
    begin
        lim_ext  = SUM_W'(region_limit[OFS_W-1:0]);
        hdr_end  = SUM_W'(offset_next) + SUM_W'(lrhc_pkg::HDR_BYTES);
        body_end = hdr_end + SUM_W'(fields_next.cipher_length[CW-1:0]);
    end

    // Per-byte decisions
    always_comb
    begin
        hdr_trunc  = record_first && (hdr_end > lim_ext);
        proc       = act_cur && !hdr_trunc;
        cnt_inc    = cnt_cur + CW'(1);
        crc_next   = (proc && (cnt_cur >= lrhc_pkg::CRC_DONE_CNT))
                   ? lrhc_pkg::crc32_byte(crc_cur, data_byte) : crc_cur;
        rec_total  = lrhc_pkg::HDR_BYTES_CNT + fields_next.cipher_length[CW-1:0];
        eol        = proc && (cnt_inc == lrhc_pkg::CRC_DONE_CNT)
                   && (fields_next.stored_crc == '0);
        at_hdr_end = proc && (cnt_inc == lrhc_pkg::HDR_BYTES_CNT);
        too_big    = at_hdr_end && (fields_next.cipher_length > lrhc_pkg::MAX_CIPHER);
        body_trunc = at_hdr_end && !too_big && (body_end > lim_ext);
        done       = proc && !too_big && !body_trunc
                   && (cnt_inc >= lrhc_pkg::HDR_BYTES_CNT) && (cnt_inc == rec_total);

        cap.clear  = record_first;
        cap.load   = proc && (cnt_cur < lrhc_pkg::HDR_BYTES_CNT);
        cap.index  = cnt_cur[5:0];

        res.emit   = hdr_trunc | eol | too_big | body_trunc | done;
        priority if (hdr_trunc)
            res.status = lrhc_pkg::ST_HDR_TRUNC;
        else if (eol)
            res.status = lrhc_pkg::ST_END_OF_LOG;
        else if (too_big)
            res.status = lrhc_pkg::ST_CIPHER_BIG;
        else if (body_trunc)
            res.status = lrhc_pkg::ST_BODY_TRUNC;
        else if (~crc_next == fields_next.stored_crc)
            res.status = lrhc_pkg::ST_OK;
        else
            res.status = lrhc_pkg::ST_CRC_BAD;
        res.total   = (res.status == lrhc_pkg::ST_OK) ? rec_total : '0;

        count_next  = proc ? cnt_inc : cnt_cur;
        active_next = act_cur && !res.emit;
    end

    // Record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            count_reg  <= '0;
            crc_reg    <= lrhc_pkg::CRC_INIT;
            offset_reg <= '0;
        end
        else if (step)
        begin
            active_reg <= active_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            offset_reg <= offset_next;
        end
    end

endmodule

// ===== design/log_record_header_checker_unit.sv =====
// Top level of the log record header checker: stream ports, APB register, stages.
//
//  channel   | direction | contents
//  s_*       | in        | one record byte per word, first-byte flag, start offset
//  m_*       | out       | one result per record: status and captured header fields
//  APB       | in/out    | region_limit at byte address 0
//
// Each byte passes through the parse stage; a byte is taken every cycle unless a result waits on m_tready.
// A taken byte sits in the input register and its result is registered in the result
// register when the parse stage advances, which raises m_tvalid.
// The running CRC and byte count update together with each byte the parse stage takes.
// Reset clears region_limit, the record state and both stage valids.
// A result waiting on m_tready holds the parse stage for every byte; s_tready
// then drops once the input register is full.
module log_record_header_checker_unit #(
    parameter int OFFSET_BITS = lrhc_pkg::OFFSET_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // data_byte[7:0], record_offset[39:8]
    input  logic        s_tuser,   // record_first
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [lrhc_pkg::OUT_DATA_W-1:0] m_tdata, // timestamp[63:0],
                                   // sequence_number[127:64], operation[135:128],
                                   // key_length[151:136], value_length[183:152],
                                   // cipher_length[215:184], nonce_low[279:216],
                                   // nonce_high[311:280], tag_low[375:312],
                                   // tag_high[439:376], total_length[467:440]
    output logic [2:0]  m_tuser,   // record_status
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    `include "log_record_header_checker_unit_macros.svh"

    logic [31:0] region_limit_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_first_reg;
    logic [31:0] in_offset_reg;

    logic                  advance;
    logic                  out_free;
    lrhc_pkg::cap_ctrl_t   cap;
    lrhc_pkg::result_t     res;
    lrhc_pkg::hdr_fields_t fields_next;

    logic                           out_valid_reg;
    lrhc_pkg::rec_status_t          out_status_reg;
    lrhc_pkg::hdr_fields_t          out_hdr_reg;
    logic [lrhc_pkg::COUNT_W-1:0]   out_total_reg;

    // APB register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lrhc_pkg::REG_REGION_LIMIT) ? region_limit_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_limit_reg <= '0;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == lrhc_pkg::REG_REGION_LIMIT))
        begin
            region_limit_reg <= pwdata;
        end
    end

    // Stage handshakes
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg   <= s_tdata[7:0];
            in_offset_reg <= s_tdata[39:8];
            in_first_reg  <= s_tuser;
        end
    end

    // Parse stage
    lrhc_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data_byte     (in_byte_reg),
        .record_first  (in_first_reg),
        .record_offset (in_offset_reg),
        .region_limit  (region_limit_reg),
        .fields_next   (fields_next),
        .cap           (cap),
        .res           (res)
    );

    lrhc_field_capture u_capture (
        .clk         (clk),
        .step        (advance),
        .data_byte   (in_byte_reg),
        .cap         (cap),
        .fields_next (fields_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            out_status_reg <= res.status;
            out_hdr_reg    <= fields_next;
            out_total_reg  <= res.total;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{lrhc_pkg::OUT_PAD_W{1'b0}}, out_total_reg,
                       out_hdr_reg.tag_high, out_hdr_reg.tag_low,
                       out_hdr_reg.nonce_high, out_hdr_reg.nonce_low,
                       out_hdr_reg.cipher_length, out_hdr_reg.value_length,
                       out_hdr_reg.key_length, out_hdr_reg.operation,
                       out_hdr_reg.sequence_number, out_hdr_reg.timestamp};

    // Checks
    `LRHC_ASSERT_NOW(a_trunc_hdr_zero, clk, rst_n, out_valid_reg && (out_status_reg == lrhc_pkg::ST_HDR_TRUNC), out_hdr_reg == '0, "header truncated result carries header data")
    `LRHC_ASSERT_NOW(a_total_only_ok, clk, rst_n, out_valid_reg && (out_status_reg != lrhc_pkg::ST_OK), out_total_reg == '0, "total length set on a failed record")
    `LRHC_ASSERT_NOW(a_eol_fields_zero, clk, rst_n, out_valid_reg && (out_status_reg == lrhc_pkg::ST_END_OF_LOG), (out_hdr_reg.timestamp == '0) && (out_hdr_reg.cipher_length == '0) && (out_hdr_reg.stored_crc == '0), "end of log result carries header data")
    `LRHC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !advance, in_valid_reg && $stable(in_byte_reg) && $stable(in_first_reg), "stalled input word lost")

endmodule
